// ===== rtl/qmn_pkg.sv =====
// Shared types, constants and helper functions of the quaternion multiply/normalize core.
package qmn_pkg;

  localparam int CW        = 16;
  localparam int FRAC      = CW - 2;
  localparam int AW        = 2 * CW + 2;
  localparam int RW        = CW + 1;
  localparam int SQ_STEPS  = AW / 2;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int QW        = FRAC + 1;
  localparam int DIV_CNT_W = $clog2(QW);
  localparam int NW        = CW + FRAC;

  localparam logic signed [CW-1:0] Q_ONE    = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [AW-1:0] RND_HALF = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_MUL   = 2'd0,
    CMD_NORM  = 2'd1,
    CMD_IDENT = 2'd2,
    CMD_HOLD  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_MUL_STORE,
    ST_SQ_ISSUE,
    ST_SQ_WAIT,
    ST_SQ_CHECK,
    ST_SQRT,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [CW-1:0] operand_w;
    logic signed [CW-1:0] operand_x;
    logic signed [CW-1:0] operand_y;
    logic signed [CW-1:0] operand_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] result_w;
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic signed [CW-1:0] result_z;
    logic                 saturated;
    logic                 zero_norm;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 sat;
  } clip_t;

  typedef struct packed {
    logic [1:0] b_idx;
    logic       neg;
  } term_t;

  // Hamilton product: term t of component c uses state[t] times operand[b_idx].
  function automatic term_t term_sel(input logic [1:0] comp, input logic [1:0] trm);
    term_t t;
    case ({comp, trm})
      4'h0:    t = '{b_idx: 2'd0, neg: 1'b0};
      4'h1:    t = '{b_idx: 2'd1, neg: 1'b1};
      4'h2:    t = '{b_idx: 2'd2, neg: 1'b1};
      4'h3:    t = '{b_idx: 2'd3, neg: 1'b1};
      4'h4:    t = '{b_idx: 2'd1, neg: 1'b0};
      4'h5:    t = '{b_idx: 2'd0, neg: 1'b0};
      4'h6:    t = '{b_idx: 2'd3, neg: 1'b0};
      4'h7:    t = '{b_idx: 2'd2, neg: 1'b1};
      4'h8:    t = '{b_idx: 2'd2, neg: 1'b0};
      4'h9:    t = '{b_idx: 2'd3, neg: 1'b1};
      4'hA:    t = '{b_idx: 2'd0, neg: 1'b0};
      4'hB:    t = '{b_idx: 2'd1, neg: 1'b0};
      4'hC:    t = '{b_idx: 2'd3, neg: 1'b0};
      4'hD:    t = '{b_idx: 2'd2, neg: 1'b0};
      4'hE:    t = '{b_idx: 2'd1, neg: 1'b1};
      default: t = '{b_idx: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

  function automatic clip_t clip_fn(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    clip_t r;
    hi = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r.val = hi[CW-1:0];
      r.sat = 1'b1;
    end else if (v < lo) begin
      r.val = lo[CW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[CW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/qmn_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
module qmn_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic                          first,
  input  logic                          neg,
  input  logic signed [qmn_pkg::CW-1:0] a,
  input  logic signed [qmn_pkg::CW-1:0] b,
  output logic signed [qmn_pkg::AW-1:0] acc
);
  import qmn_pkg::*;

  logic signed [2*CW-1:0] prod_r;
  logic                   neg_r;
  logic                   first_r;
  logic                   vld_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;
  logic signed [AW-1:0]   base;
  logic signed [AW-1:0]   addend;

  always_comb begin
    base    = first_r ? '0 : acc_r;
    addend  = AW'(prod_r);
    acc_nxt = acc_r;
    if (vld_r) begin
      acc_nxt = neg_r ? (base - addend) : (base + addend);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= a * b;
    neg_r   <= neg;
    first_r <= first;
    acc_r   <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/qmn_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module qmn_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [qmn_pkg::AW-1:0] radicand,
  output logic                   busy,
  output logic [qmn_pkg::RW-1:0] root
);
  import qmn_pkg::*;

  logic [AW-1:0]       s_r;
  logic [RW-1:0]       root_r;
  logic [RW+1:0]       rem_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic [RW+3:0]       cand;
  logic [RW+3:0]       trial;
  logic [RW+3:0]       diff;
  logic                ge;

  always_comb begin
    cand  = {rem_r, s_r[AW-1:AW-2]};
    trial = (RW+4)'({root_r, 2'b01});
    diff  = cand - trial;
    ge    = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SQ_CNT_W'(SQ_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r    <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      s_r    <= s_r << 2;
      root_r <= {root_r[RW-2:0], ge};
      rem_r  <= ge ? diff[RW+1:0] : cand[RW+1:0];
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== rtl/qmn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module qmn_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [qmn_pkg::NW-1:0] num,
  input  logic [qmn_pkg::RW-1:0] den,
  output logic                   busy,
  output logic [qmn_pkg::QW-1:0] quot
);
  import qmn_pkg::*;

  logic [RW-1:0]        rem_r;
  logic [RW-1:0]        den_r;
  logic [QW-1:0]        nb_r;
  logic [QW-1:0]        quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [RW:0]          cand;
  logic [RW:0]          diff;
  logic                 ge;

  always_comb begin
    cand = {rem_r, nb_r[QW-1]};
    diff = cand - {1'b0, den_r};
    ge   = (cand >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(QW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient fits QW bits, so the top of the numerator is already below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= RW'(num[NW-1:QW]);
      nb_r   <= num[QW-1:0];
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[RW-1:0] : cand[RW-1:0];
      nb_r   <= nb_r << 1;
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

// ===== rtl/quaternion_multiply_normalise_core.sv =====
// Top level: attitude quaternion register with multiply, normalize and identity reload.
//
// Input channel in_valid/in_ready/in_item carries a command and a Q2.14 operand quaternion.
// Result channel out_valid/out_ready/out_item returns the new attitude and two flags,
// one item per input item, in order.
// Work per item, accept to result valid:
//   multiply   sixteen products through the one multiply-accumulate unit,
//              four per component, then the result is handed off
//   normalize  four squares, 17-step square root, then four 15-step divides
//   identity / unused command  straight to the result hand-off
// Zero-norm normalize ends after the sum of squares.
// in_ready is high only while the sequencer is idle; one item is in work at a time,
// and in_ready rises in the same cycle that the previous result goes valid.
// A finished result sits in the output register; the next item can be accepted while
// it waits. If the receiver stalls, the sequencer holds its finished item until the
// output register frees up.
// Reset loads the identity quaternion, clears the output valid flag and idles the
// sequencer.
module quaternion_multiply_normalise_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qmn_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output qmn_pkg::out_item_t out_item
);
  import qmn_pkg::*;

  state_t               state_r, state_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic signed [CW-1:0] q_r [4];
  logic signed [CW-1:0] q_nxt [4];
  logic signed [CW-1:0] nq_r [4];
  logic signed [CW-1:0] nq_nxt [4];
  logic signed [CW-1:0] op_r [4];
  logic signed [CW-1:0] op_nxt [4];
  logic                 sat_r, sat_nxt;
  logic                 zn_r, zn_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [1:0]           comp;
  logic [1:0]           trm;
  logic [1:0]           qidx;
  term_t                tsel;
  logic signed [CW-1:0] q_sel;
  logic [CW-1:0]        q_mag;

  logic                 mac_issue;
  logic                 mac_first;
  logic                 mac_neg;
  logic signed [CW-1:0] mac_a;
  logic signed [CW-1:0] mac_b;
  logic signed [AW-1:0] mac_acc;
  logic signed [AW-1:0] rounded;
  clip_t                mul_clip;

  logic                 sq_start;
  logic                 sq_busy;
  logic [RW-1:0]        sq_root;

  logic                 div_start;
  logic                 div_busy;
  logic [NW-1:0]        div_num;
  logic [QW-1:0]        div_quot;
  logic signed [AW-1:0] div_val;
  clip_t                div_clip;

  qmn_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (mac_issue),
    .first (mac_first),
    .neg   (mac_neg),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc)
  );

  qmn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mac_acc),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  qmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sq_root),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_comb begin
    comp      = cnt_r[3:2];
    trm       = cnt_r[1:0];
    tsel      = term_sel(comp, trm);
    qidx      = (state_r == ST_DIV_START) ? comp : trm;
    q_sel     = q_r[qidx];
    q_mag     = q_sel[CW-1] ? (~q_sel + 1'b1) : q_sel;

    mac_issue = (state_r == ST_MUL_ISSUE) || (state_r == ST_SQ_ISSUE);
    mac_first = (trm == 2'd0);
    mac_neg   = (state_r == ST_MUL_ISSUE) && tsel.neg;
    mac_a     = q_sel;
    mac_b     = (state_r == ST_SQ_ISSUE) ? q_sel : op_r[tsel.b_idx];

    rounded   = (mac_acc + RND_HALF) >>> FRAC;
    mul_clip  = clip_fn(rounded);

    div_num   = {q_mag, {FRAC{1'b0}}} + NW'(sq_root >> 1);
    div_val   = neg_r ? -AW'(div_quot) : AW'(div_quot);
    div_clip  = clip_fn(div_val);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    nq_nxt        = nq_r;
    op_nxt        = op_r;
    sat_nxt       = sat_r;
    zn_nxt        = zn_r;
    neg_nxt       = neg_r;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt[0] = in_item.operand_w;
          op_nxt[1] = in_item.operand_x;
          op_nxt[2] = in_item.operand_y;
          op_nxt[3] = in_item.operand_z;
          cnt_nxt   = '0;
          sat_nxt   = 1'b0;
          zn_nxt    = 1'b0;
          unique case (cmd_t'(in_item.command))
            CMD_MUL:  state_nxt = ST_MUL_ISSUE;
            CMD_NORM: state_nxt = ST_SQ_ISSUE;
            CMD_IDENT: begin
              nq_nxt[0] = Q_ONE;
              nq_nxt[1] = '0;
              nq_nxt[2] = '0;
              nq_nxt[3] = '0;
              state_nxt = ST_DONE;
            end
            CMD_HOLD: begin
              nq_nxt    = q_r;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL_ISSUE: begin
        if (trm == 2'd3) begin
          state_nxt = ST_MUL_WAIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL_WAIT: state_nxt = ST_MUL_STORE;
      ST_MUL_STORE: begin
        nq_nxt[comp] = mul_clip.val;
        sat_nxt      = sat_r | mul_clip.sat;
        cnt_nxt      = cnt_r + 1'b1;
        state_nxt    = (comp == 2'd3) ? ST_DONE : ST_MUL_ISSUE;
      end
      ST_SQ_ISSUE: begin
        if (trm == 2'd3) begin
          state_nxt = ST_SQ_WAIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQ_WAIT: state_nxt = ST_SQ_CHECK;
      ST_SQ_CHECK: begin
        cnt_nxt = '0;
        if (mac_acc == '0) begin
          zn_nxt    = 1'b1;
          nq_nxt    = q_r;
          state_nxt = ST_DONE;
        end else begin
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!sq_busy) begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        neg_nxt   = q_sel[CW-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          nq_nxt[comp] = div_clip.val;
          sat_nxt      = sat_r | div_clip.sat;
          cnt_nxt      = cnt_r + 4'd4;
          state_nxt    = (comp == 2'd3) ? ST_DONE : ST_DIV_START;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          q_nxt                  = nq_r;
          out_item_nxt.result_w  = nq_r[0];
          out_item_nxt.result_x  = nq_r[1];
          out_item_nxt.result_y  = nq_r[2];
          out_item_nxt.result_z  = nq_r[3];
          out_item_nxt.saturated = sat_r;
          out_item_nxt.zero_norm = zn_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      q_r[0]      <= Q_ONE;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r       <= nq_nxt;
    op_r       <= op_nxt;
    sat_r      <= sat_nxt;
    zn_r       <= zn_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/qmn_checker.sv =====
// Port-level assertions for the quaternion core, bound to the top level.
module qmn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input qmn_pkg::out_item_t out_item
);
  import qmn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready right after taking an item");

  a_zero_norm_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_norm |->
      out_item.result_w == '0 && out_item.result_x == '0 &&
      out_item.result_y == '0 && out_item.result_z == '0 && !out_item.saturated)
    else $error("zero norm flagged on a nonzero or saturated state");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("core not idle after reset");

endmodule

bind quaternion_multiply_normalise_core qmn_checker u_qmn_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the attitude quaternion multiply/normalize core.
`timescale 1ns / 1ps

module testbench;
  import qmn_pkg::*;

  localparam int RANDOM_ITEMS   = 850;
  localparam int LONG_HOLD      = 400;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 150;

  typedef enum int {RX_STEADY, RX_MOSTLY, RX_TOGGLE, RX_CHOKED} rx_mode_t;

  // Tracks the attitude quaternion and the results still owed by the core.
  class attitude_tracker;
    longint    att[4];
    out_item_t owed[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_command[4];
    int unsigned sat_seen;
    int unsigned zero_norm_seen;

    function new();
      load_identity();
    endfunction

    function void load_identity();
      att[0] = longint'(Q_ONE);
      att[1] = 0;
      att[2] = 0;
      att[3] = 0;
    endfunction

    function logic [CW-1:0] clamp(longint v, inout bit sat);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        v = hi;
      end else if (v < lo) begin
        sat = 1'b1;
        v = lo;
      end
      return v[CW-1:0];
    endfunction

    function void note_command(in_item_t it);
      longint    b[4];
      longint    acc[4];
      longint    sum_sq;
      longint    root;
      longint    trial;
      longint    mag;
      longint    quo;
      bit        sat;
      bit        zn;
      out_item_t exp_item;
      sat = 1'b0;
      zn  = 1'b0;
      per_command[it.command]++;
      case (cmd_t'(it.command))
        CMD_MUL: begin
          b[0] = longint'(it.operand_w);
          b[1] = longint'(it.operand_x);
          b[2] = longint'(it.operand_y);
          b[3] = longint'(it.operand_z);
          acc[0] = att[0] * b[0] - att[1] * b[1] - att[2] * b[2] - att[3] * b[3];
          acc[1] = att[0] * b[1] + att[1] * b[0] + att[2] * b[3] - att[3] * b[2];
          acc[2] = att[0] * b[2] - att[1] * b[3] + att[2] * b[0] + att[3] * b[1];
          acc[3] = att[0] * b[3] + att[1] * b[2] - att[2] * b[1] + att[3] * b[0];
          for (int i = 0; i < 4; i++) begin
            acc[i] = (acc[i] + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            att[i] = longint'($signed(clamp(acc[i], sat)));
          end
        end
        CMD_NORM: begin
          sum_sq = 0;
          for (int i = 0; i < 4; i++) sum_sq += att[i] * att[i];
          if (sum_sq == 0) begin
            zn = 1'b1;
          end else begin
            root = 0;
            for (int k = 16; k >= 0; k--) begin
              trial = root | (longint'(1) <<< k);
              if (trial * trial <= sum_sq) root = trial;
            end
            for (int i = 0; i < 4; i++) begin
              mag = (att[i] < 0 ? -att[i] : att[i]) <<< FRAC;
              quo = (mag + root / 2) / root;
              if (att[i] < 0) quo = -quo;
              att[i] = longint'($signed(clamp(quo, sat)));
            end
          end
        end
        CMD_IDENT: load_identity();
        default: ;
      endcase
      exp_item.result_w  = att[0][CW-1:0];
      exp_item.result_x  = att[1][CW-1:0];
      exp_item.result_y  = att[2][CW-1:0];
      exp_item.result_z  = att[3][CW-1:0];
      exp_item.saturated = sat;
      exp_item.zero_norm = zn;
      if (sat) sat_seen++;
      if (zn) zero_norm_seen++;
      owed.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item with nothing owed: w=%0d x=%0d y=%0d z=%0d sat=%0b zn=%0b",
                   $realtime, got.result_w, got.result_x, got.result_y, got.result_z,
                   got.saturated, got.zero_norm);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.result_w !== want.result_w || got.result_x !== want.result_x ||
          got.result_y !== want.result_y || got.result_z !== want.result_z ||
          got.saturated !== want.saturated || got.zero_norm !== want.zero_norm) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch on result %0d", $realtime, checked);
          $display("  expected w=%0d x=%0d y=%0d z=%0d sat=%0b zn=%0b",
                   want.result_w, want.result_x, want.result_y, want.result_z,
                   want.saturated, want.zero_norm);
          $display("  actual   w=%0d x=%0d y=%0d z=%0d sat=%0b zn=%0b",
                   got.result_w, got.result_x, got.result_y, got.result_z,
                   got.saturated, got.zero_norm);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  attitude_tracker book;
  bit              backpressure_request;

  quaternion_multiply_normalise_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", book.owed.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t make_item(cmd_t c, int w, int x, int y, int z);
    in_item_t it;
    it.command   = c;
    it.operand_w = CW'(w);
    it.operand_x = CW'(x);
    it.operand_y = CW'(y);
    it.operand_z = CW'(z);
    return it;
  endfunction

  function automatic int pick_component(int unsigned style);
    case (style)
      0: return int'($urandom_range(0, 32768)) - 16384;
      1: return int'($urandom_range(0, 2048)) - 1024;
      2: return int'($urandom_range(0, 65535)) - 32768;
      default: begin
        case ($urandom_range(0, 6))
          0: return -32768;
          1: return 32767;
          2: return -16384;
          3: return 16384;
          4: return 1;
          5: return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_item();
    int unsigned roll;
    int unsigned style;
    cmd_t        c;
    roll  = $urandom_range(0, 99);
    style = $urandom_range(0, 99) < 40 ? 0 :
            $urandom_range(0, 99) < 45 ? 1 :
            $urandom_range(0, 99) < 70 ? 2 : 3;
    if (roll < 2) return make_item(CMD_MUL, 0, 0, 0, 0);
    if (roll < 57) c = CMD_MUL;
    else if (roll < 82) c = CMD_NORM;
    else if (roll < 90) c = CMD_IDENT;
    else if (roll < 95) c = CMD_HOLD;
    else begin
      c = CMD_MUL;
      style = 2;
    end
    if (c != CMD_MUL) style = 2;
    return make_item(c, pick_component(style), pick_component(style),
                     pick_component(style), pick_component(style));
  endfunction

  task automatic offer(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    book.note_command(it);
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_item);
  end

  // Receiver: random ready patterns, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned phase_left;
    rx_mode_t    mode;
    out_ready  = 1'b0;
    stall_left = 0;
    phase_left = 0;
    mode       = RX_STEADY;
    forever begin
      @(negedge clk);
      if (backpressure_request) begin
        backpressure_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        if (phase_left == 0) begin
          mode       = rx_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(4, 40);
        end
        phase_left--;
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_ready <= phase_left[0];
          default:   out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  initial begin
    in_item_t    directed[$];
    int unsigned burst_left;
    book                 = new();
    backpressure_request = 1'b0;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_item              = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(make_item(CMD_IDENT, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_HOLD, -1, -1, -1, -1));
    directed.push_back(make_item(CMD_MUL, 16384, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, 0, 16384, 0, 0));
    directed.push_back(make_item(CMD_MUL, 0, 0, 16384, 0));
    directed.push_back(make_item(CMD_MUL, 0, 0, 0, 16384));
    directed.push_back(make_item(CMD_NORM, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, -32768, -32768, -32768, -32768));
    directed.push_back(make_item(CMD_MUL, 32767, 32767, 32767, 32767));
    directed.push_back(make_item(CMD_NORM, -1, 0, -1, 0));
    directed.push_back(make_item(CMD_IDENT, 32767, 32767, 32767, 32767));
    directed.push_back(make_item(CMD_MUL, 32767, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, 32767, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, -32768, -32768, -32768, -32768));
    directed.push_back(make_item(CMD_NORM, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_IDENT, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, 1, -1, 1, -1));
    directed.push_back(make_item(CMD_NORM, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_MUL, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_NORM, 0, 0, 0, 0));
    directed.push_back(make_item(CMD_HOLD, 32767, -32768, 32767, -32768));
    directed.push_back(make_item(CMD_MUL, 12345, -4321, 777, -9999));
    directed.push_back(make_item(CMD_IDENT, -32768, -32768, -32768, -32768));
    directed.push_back(make_item(CMD_HOLD, 0, 0, 0, 0));

    foreach (directed[i]) begin
      offer(directed[i]);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
    end

    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        backpressure_request = 1'b1;
        burst_left = 60;
      end
      offer(random_item());
      burst_left--;
      if (burst_left == 0) begin
        pause($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 30);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d multiply, %0d normalize, %0d identity, %0d unused-command items",
             book.per_command[CMD_MUL], book.per_command[CMD_NORM],
             book.per_command[CMD_IDENT], book.per_command[CMD_HOLD]);
    $display("checked %0d results (%0d saturating, %0d zero-norm), %0d errors",
             book.checked, book.sat_seen, book.zero_norm_seen, book.errors);
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qmn_pkg.sv
rtl/qmn_mac.sv
rtl/qmn_sqrt.sv
rtl/qmn_div.sv
rtl/quaternion_multiply_normalise_core.sv
rtl/qmn_checker.sv
dv/testbench.sv
